// ===== hw/rtl/sdta_pkg.sv =====
// ----------------------------------------------------------------------------
// sdta_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sdta_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift_bin;
    logic shift_dig;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed integer to its decimal ASCII text, most significant
// character first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                      tlast             tuser
//  s_*       in   value [63:0]               -                 -
//  m_*       out  char_code [5:0], 0 [7:6]   last char of text -
//
//  per item: accept, conversion shifts through the digit cell chain,
//  leading zero skips, a minus sign for a negative value, leaving the
//  skip state, then the digits; the minus sign and the digits wait while
//  the output register is full and m_tready stays low.
//  one item at a time; s_tready is high only once the last character of the
//  previous text is in the output register.
//  rst is synchronous and clears control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // value [63:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // char_code [5:0], zero [7:6]
  output logic        m_tlast
);

  localparam int unsigned NDIG  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);
  localparam int unsigned REM_W = $clog2(NDIG);

  sdta_pkg::state_t     state, state_next;
  sdta_pkg::cell_ctrl_t ctrl;

  logic [VALUE_WIDTH-1:0] mag, mag_next;
  logic                   neg, neg_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [REM_W-1:0]       rem, rem_next;

  logic                   out_free;
  logic                   out_load;
  logic [sdta_pkg::CHAR_W-1:0] out_char;
  logic                   out_last;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;

  logic                         carry [NDIG+1];
  logic [sdta_pkg::DIGIT_W-1:0] digit [NDIG];
  logic [sdta_pkg::DIGIT_W-1:0] top;

  assign in_val   = s_tdata[VALUE_WIDTH-1:0];
  assign in_neg   = in_val[VALUE_WIDTH-1];
  assign s_tready = (state == sdta_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign carry[0] = mag[VALUE_WIDTH-1];
  assign top      = digit[NDIG-1];

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic [sdta_pkg::DIGIT_W-1:0] dig_in;
    if (i == 0) begin : g_low
      assign dig_in = '0;
    end else begin : g_up
      assign dig_in = digit[i-1];
    end
    sdta_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .bit_in  (carry[i]),
      .dig_in  (dig_in),
      .bit_out (carry[i+1]),
      .digit   (digit[i])
    );
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    neg_next       = neg;
    cnt_next       = cnt;
    rem_next       = rem;
    ctrl.clear     = 1'b0;
    ctrl.shift_bin = 1'b0;
    ctrl.shift_dig = 1'b0;
    out_load       = 1'b0;
    out_char       = sdta_pkg::CHAR_ZERO;
    out_last       = 1'b0;
    case (state)
      sdta_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          ctrl.clear = 1'b1;
          neg_next   = in_neg;
          mag_next   = in_neg ? (~in_val + 1'b1) : in_val;
          cnt_next   = CNT_W'(VALUE_WIDTH - 1);
          state_next = sdta_pkg::ST_CONV;
        end
      end
      sdta_pkg::ST_CONV: begin
        ctrl.shift_bin = 1'b1;
        mag_next       = {mag[VALUE_WIDTH-2:0], 1'b0};
        cnt_next       = cnt - 1'b1;
        if (cnt == '0) begin
          rem_next   = REM_W'(NDIG - 1);
          state_next = sdta_pkg::ST_SKIP;
        end
      end
      sdta_pkg::ST_SKIP: begin
        if (top == '0 && rem != '0) begin
          ctrl.shift_dig = 1'b1;
          rem_next       = rem - 1'b1;
        end else if (neg) begin
          if (out_free) begin
            out_load = 1'b1;
            out_char = sdta_pkg::CHAR_MINUS;
            neg_next = 1'b0;
          end
        end else begin
          state_next = sdta_pkg::ST_EMIT;
        end
      end
      sdta_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_char       = sdta_pkg::CHAR_ZERO + {2'b00, top};
          out_last       = (rem == '0);
          ctrl.shift_dig = 1'b1;
          rem_next       = rem - 1'b1;
          if (rem == '0) begin
            state_next = sdta_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sdta_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sdta_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    neg <= neg_next;
    cnt <= cnt_next;
    rem <= rem_next;
    if (out_load) begin
      m_tdata <= {2'b00, out_char};
      m_tlast <= out_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sdta_cell.sv =====
// ----------------------------------------------------------------------------
// sdta_cell
// One decimal digit cell: add-3 and shift during conversion, digit shift
// toward the top during output.
// ----------------------------------------------------------------------------
`default_nettype none

module sdta_cell (
  input  wire                                clk,
  input  wire  sdta_pkg::cell_ctrl_t         ctrl,
  input  wire                                bit_in,
  input  wire  [sdta_pkg::DIGIT_W-1:0]       dig_in,
  output logic                               bit_out,
  output logic [sdta_pkg::DIGIT_W-1:0]       digit
);

  logic [sdta_pkg::DIGIT_W-1:0] adj;

  always_comb begin
    if (digit >= 4'd5) begin
      adj = digit + 4'd3;
    end else begin
      adj = digit;
    end
  end

  assign bit_out = adj[sdta_pkg::DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift_bin) begin
      digit <= {adj[sdta_pkg::DIGIT_W-2:0], bit_in};
    end else if (ctrl.shift_dig) begin
      digit <= dig_in;
    end
  end

endmodule

`default_nettype wire
